// ----- rtl/s2tm_pkg.sv -----
// Shared types, constants and helper functions of the segment-to-tube block.
// Used by s2tm_fifo, s2tm_front, s2tm_back and segment_to_tube_mesh.
// No dependencies.
package s2tm_pkg;

  // Vertex numbering width and fixed-point constants.
  localparam int unsigned INDEX_BITS   = 24;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned MIN_FACETS   = 3;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [31:0] DEFAULT_RADIUS = 32'd6554;
  localparam logic [6:0]  RESET_FACETS   = 7'd8;
  localparam logic signed [16:0] UNIT_Q15     = 17'sd32768;
  localparam logic signed [16:0] NEG_UNIT_Q15 = -17'sd32768;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  // Register indexes on the configuration port.
  localparam logic REG_TUBE_RADIUS = 1'b0;
  localparam logic REG_FACET_COUNT = 1'b1;

  // One segment as it arrives.
  typedef struct packed {
    logic signed [31:0] begin_x;
    logic signed [31:0] begin_y;
    logic signed [31:0] begin_z;
    logic signed [31:0] finish_x;
    logic signed [31:0] finish_y;
    logic signed [31:0] finish_z;
    logic               restart;
  } in_item_t;

  // One facet result.
  typedef struct packed {
    logic signed [31:0]     near_x;
    logic signed [31:0]     near_y;
    logic signed [31:0]     near_z;
    logic signed [31:0]     far_x;
    logic signed [31:0]     far_y;
    logic signed [31:0]     far_z;
    logic [INDEX_BITS-1:0]  quad_a;
    logic [INDEX_BITS-1:0]  quad_b;
    logic [INDEX_BITS-1:0]  quad_c;
    logic [INDEX_BITS-1:0]  quad_d;
    logic                   last_facet;
  } out_item_t;

  // A classified segment: endpoints plus the rotation factors in Q15.
  typedef struct packed {
    logic signed [31:0] begin_x;
    logic signed [31:0] begin_y;
    logic signed [31:0] begin_z;
    logic signed [31:0] finish_x;
    logic signed [31:0] finish_y;
    logic signed [31:0] finish_z;
    logic signed [16:0] sz;
    logic signed [16:0] cz;
    logic signed [16:0] cy;
    logic signed [16:0] m02;
    logic signed [16:0] m12;
    logic               restart;
  } job_t;

  // Round a Q15-scaled product to the nearest, halves going up.
  function automatic logic signed [63:0] rnd15(input logic signed [63:0] v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  // CORDIC arctangent steps, in units of 2^-32 turn.
  function automatic logic [29:0] atan_turns(input logic [4:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:    val = 30'd536870912;
      5'd1:    val = 30'd316933406;
      5'd2:    val = 30'd167458907;
      5'd3:    val = 30'd85004756;
      5'd4:    val = 30'd42667331;
      5'd5:    val = 30'd21354465;
      5'd6:    val = 30'd10679838;
      5'd7:    val = 30'd5340245;
      5'd8:    val = 30'd2670163;
      5'd9:    val = 30'd1335087;
      5'd10:   val = 30'd667544;
      5'd11:   val = 30'd333772;
      5'd12:   val = 30'd166886;
      5'd13:   val = 30'd83443;
      5'd14:   val = 30'd41722;
      5'd15:   val = 30'd20861;
      5'd16:   val = 30'd10430;
      5'd17:   val = 30'd5215;
      5'd18:   val = 30'd2608;
      5'd19:   val = 30'd1304;
      5'd20:   val = 30'd652;
      5'd21:   val = 30'd326;
      5'd22:   val = 30'd163;
      5'd23:   val = 30'd81;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/s2tm_fifo.sv -----
// Two-entry queue of classified segments between the front and back parts.
// Depends on s2tm_pkg (job_t, QUEUE_DEPTH).
module s2tm_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  s2tm_pkg::job_t   push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output s2tm_pkg::job_t   pop_data_o
);

  localparam int unsigned PW = $clog2(s2tm_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(s2tm_pkg::QUEUE_DEPTH + 1);

  s2tm_pkg::job_t mem_q [s2tm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign push_ready_o = (count_q != CW'(s2tm_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(s2tm_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(s2tm_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/s2tm_front.sv -----
// Front part: accepts a segment and derives the rotation factors of its
// direction with a shared normalizer, square-root and divider sequence.
// Depends on s2tm_pkg (in_item_t, job_t, rnd15, Q15 constants).
module s2tm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  s2tm_pkg::in_item_t   in_data_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output s2tm_pkg::job_t       push_data_o
);

  typedef enum logic [2:0] {
    F_IDLE, F_DIFF, F_NORM, F_SQR, F_ROOT, F_DIV, F_PROD, F_PUSH
  } fstate_e;

  fstate_e             state_q, state_d;
  s2tm_pkg::in_item_t  in_q, in_d;
  logic [2:0]          dneg_q, dneg_d;
  logic [32:0]         mag_q [3];
  logic [32:0]         mag_d [3];
  logic [32:0]         t_q [3];
  logic [32:0]         t_d [3];
  logic                pass_q, pass_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [59:0]         sq0_q, sq0_d;
  logic [60:0]         sxy_q, sxy_d;
  logic [61:0]         rv_q, rv_d;
  logic [62:0]         rres_q, rres_d, rbit_q, rbit_d;
  logic                ridx_q, ridx_d;
  logic [31:0]         hxyz_q, hxyz_d, hxy_q, hxy_d;
  logic [31:0]         drem_q, drem_d;
  logic [15:0]         dquo_q, dquo_d;
  logic                didx_q, didx_d;
  logic signed [16:0]  sy_q, sy_d, cy_q, cy_d, sz_q, sz_d, cz_q, cz_d;
  logic signed [16:0]  m02_q, m02_d, m12_q, m12_d;

  logic signed [32:0]  dif [3];
  logic                norm_big, norm_small;
  logic [29:0]         sq_op;
  logic [59:0]         sq;
  logic [62:0]         rsum;
  logic                rge;
  logic [61:0]         rv_n;
  logic [62:0]         rres_n;
  logic [31:0]         dnum, dden;
  logic                dneg;
  logic [47:0]         dn_init;
  logic [32:0]         dr2;
  logic                dge;
  logic [15:0]         dquo_n;
  logic [16:0]         qmag;
  logic signed [16:0]  qres;
  logic signed [33:0]  pm;
  logic signed [16:0]  mres;

  assign in_ready_o   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);

  // Job record handed to the queue.
  always_comb begin
    push_data_o.begin_x  = in_q.begin_x;
    push_data_o.begin_y  = in_q.begin_y;
    push_data_o.begin_z  = in_q.begin_z;
    push_data_o.finish_x = in_q.finish_x;
    push_data_o.finish_y = in_q.finish_y;
    push_data_o.finish_z = in_q.finish_z;
    push_data_o.sz       = sz_q;
    push_data_o.cz       = cz_q;
    push_data_o.cy       = cy_q;
    push_data_o.m02      = m02_q;
    push_data_o.m12      = m12_q;
    push_data_o.restart  = in_q.restart;
  end

  // Direction vector, 33 bits signed.
  assign dif[0] = {in_q.finish_x[31], in_q.finish_x} - {in_q.begin_x[31], in_q.begin_x};
  assign dif[1] = {in_q.finish_y[31], in_q.finish_y} - {in_q.begin_y[31], in_q.begin_y};
  assign dif[2] = {in_q.finish_z[31], in_q.finish_z} - {in_q.begin_z[31], in_q.begin_z};

  // Normalizer tests: largest magnitude at or above 2^30, or below 2^29.
  assign norm_big   = (|t_q[0][32:30]) || (|t_q[1][32:30]) || (|t_q[2][32:30]);
  assign norm_small = !((|t_q[0][32:29]) || (|t_q[1][32:29]) || (|t_q[2][32:29]));

  // Squarer, one component per cycle.
  assign sq_op = t_q[cnt_q[1:0]][29:0];
  assign sq    = 60'(sq_op) * 60'(sq_op);

  // One step of the bitwise integer square root.
  assign rsum   = rres_q + rbit_q;
  assign rge    = ({1'b0, rv_q} >= rsum);
  assign rv_n   = rge ? (rv_q - rsum[61:0]) : rv_q;
  assign rres_n = rge ? ((rres_q >> 1) + rbit_q) : (rres_q >> 1);

  // Divider operands: pass 0 gives sy and cy, pass 1 gives sz and cz.
  always_comb begin
    dden = pass_q ? hxy_q : hxyz_q;
    case ({pass_q, didx_q})
      2'b00:   begin dnum = t_q[2][31:0]; dneg = dneg_q[2]; end
      2'b01:   begin dnum = hxy_q;        dneg = 1'b0;      end
      2'b10:   begin dnum = t_q[1][31:0]; dneg = dneg_q[1]; end
      default: begin dnum = t_q[0][31:0]; dneg = dneg_q[0]; end
    endcase
  end

  // Restoring divider, one quotient bit per cycle.
  assign dn_init = 48'({dnum, 15'b0}) + 48'(dden >> 1);
  assign dr2     = {drem_q, dquo_q[15]};
  assign dge     = (dr2 >= {1'b0, dden});
  assign dquo_n  = {dquo_q[14:0], dge};
  always_comb begin
    if (dden == '0) begin
      qmag = '0;
    end else if ({1'b0, dquo_n} > 17'd32768) begin
      qmag = 17'd32768;
    end else begin
      qmag = {1'b0, dquo_n};
    end
    qres = dneg ? -$signed(qmag) : $signed(qmag);
  end

  // Matrix entries -cz*sy and -sz*sy.
  assign pm   = (cnt_q[0] ? sz_q : cz_q) * sy_q;
  assign mres = 17'(-s2tm_pkg::rnd15(64'(pm)));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    in_d    = in_q;
    dneg_d  = dneg_q;
    mag_d   = mag_q;
    t_d     = t_q;
    pass_d  = pass_q;
    cnt_d   = cnt_q;
    sq0_d   = sq0_q;
    sxy_d   = sxy_q;
    rv_d    = rv_q;
    rres_d  = rres_q;
    rbit_d  = rbit_q;
    ridx_d  = ridx_q;
    hxyz_d  = hxyz_q;
    hxy_d   = hxy_q;
    drem_d  = drem_q;
    dquo_d  = dquo_q;
    didx_d  = didx_q;
    sy_d    = sy_q;
    cy_d    = cy_q;
    sz_d    = sz_q;
    cz_d    = cz_q;
    m02_d   = m02_q;
    m12_d   = m12_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          state_d = F_DIFF;
        end
      end
      F_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          dneg_d[i] = dif[i][32];
          mag_d[i]  = dif[i][32] ? 33'(-dif[i]) : 33'(dif[i]);
          t_d[i]    = mag_d[i];
        end
        // Degenerate directions keep the identity-like defaults.
        sy_d   = '0;
        cy_d   = s2tm_pkg::UNIT_Q15;
        sz_d   = '0;
        cz_d   = s2tm_pkg::NEG_UNIT_Q15;
        pass_d = 1'b0;
        cnt_d  = '0;
        if ((mag_d[0] | mag_d[1] | mag_d[2]) != '0) begin
          state_d = F_NORM;
        end else begin
          state_d = F_PROD;
        end
      end
      F_NORM: begin
        if (norm_big) begin
          for (int i = 0; i < 3; i++) t_d[i] = t_q[i] >> 1;
        end else if (norm_small) begin
          for (int i = 0; i < 3; i++) t_d[i] = t_q[i] << 1;
        end else begin
          cnt_d   = '0;
          state_d = F_SQR;
        end
      end
      F_SQR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd0) begin
          sq0_d = sq;
        end else if (cnt_q == 5'd1) begin
          sxy_d = 61'(sq0_q) + 61'(sq);
        end else begin
          // Root of the full sum first in pass 0, then of the x-y sum.
          rv_d    = 62'(sxy_q) + 62'(sq);
          rres_d  = '0;
          rbit_d  = 63'(1) << 62;
          ridx_d  = pass_q;
          cnt_d   = '0;
          state_d = F_ROOT;
        end
      end
      F_ROOT: begin
        rv_d   = rv_n;
        rres_d = rres_n;
        rbit_d = rbit_q >> 2;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          cnt_d = '0;
          if (!ridx_q) begin
            hxyz_d = rres_n[31:0];
            rv_d   = 62'(sxy_q);
            rres_d = '0;
            rbit_d = 63'(1) << 62;
            ridx_d = 1'b1;
          end else begin
            hxy_d   = rres_n[31:0];
            didx_d  = 1'b0;
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd0) begin
          drem_d = dn_init[47:16];
          dquo_d = dn_init[15:0];
        end else begin
          drem_d = dge ? 32'(dr2 - {1'b0, dden}) : dr2[31:0];
          dquo_d = dquo_n;
          if (cnt_q == 5'd16) begin
            cnt_d = '0;
            case ({pass_q, didx_q})
              2'b00:   sy_d = qres;
              2'b01:   cy_d = qres;
              2'b10:   sz_d = qres;
              default: cz_d = qres;
            endcase
            if (!didx_q) begin
              didx_d = 1'b1;
            end else if (!pass_q && ((mag_q[0] | mag_q[1]) != '0)) begin
              // Second pass on the x-y projection.
              t_d[0]  = mag_q[0];
              t_d[1]  = mag_q[1];
              t_d[2]  = '0;
              pass_d  = 1'b1;
              state_d = F_NORM;
            end else begin
              state_d = F_PROD;
            end
          end
        end
      end
      F_PROD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[0]) begin
          m12_d   = mres;
          state_d = F_PUSH;
        end else begin
          m02_d = mres;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    dneg_q <= dneg_d;
    mag_q  <= mag_d;
    t_q    <= t_d;
    pass_q <= pass_d;
    cnt_q  <= cnt_d;
    sq0_q  <= sq0_d;
    sxy_q  <= sxy_d;
    rv_q   <= rv_d;
    rres_q <= rres_d;
    rbit_q <= rbit_d;
    ridx_q <= ridx_d;
    hxyz_q <= hxyz_d;
    hxy_q  <= hxy_d;
    drem_q <= drem_d;
    dquo_q <= dquo_d;
    didx_q <= didx_d;
    sy_q   <= sy_d;
    cy_q   <= cy_d;
    sz_q   <= sz_d;
    cz_q   <= cz_d;
    m02_q  <= m02_d;
    m12_q  <= m12_d;
  end

endmodule

// ----- rtl/s2tm_back.sv -----
// Back part: walks the facets of one queued segment, runs the ring CORDIC
// and the offset products, and holds each facet result in an output register.
// Depends on s2tm_pkg (job_t, out_item_t, rnd15, atan_turns, constants).
module s2tm_back #(
  parameter int unsigned MAX_FACETS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          radius_i,
  input  logic [6:0]           facets_i,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  s2tm_pkg::job_t       pop_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output s2tm_pkg::out_item_t  out_data_o
);

  localparam int unsigned FW = $clog2(MAX_FACETS + 1);
  localparam int unsigned IB = s2tm_pkg::INDEX_BITS;

  typedef enum logic [2:0] {B_IDLE, B_SETUP, B_CORDIC, B_MUL, B_EMIT} bstate_e;

  bstate_e             state_q, state_d;
  s2tm_pkg::job_t      job_q, job_d;
  logic [FW-1:0]       f_q, f_d, k_q, k_d, srem_q, srem_d;
  logic [31:0]         r_q, r_d;
  logic [IB-1:0]       base_q, base_d, a_q, a_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [31:0]         squo_q, squo_d, q0_q, q0_d, ph_q, ph_d;
  logic [FW:0]         r0_q, r0_d, phr_q, phr_d;
  logic signed [33:0]  x_q, x_d, y_q, y_d;
  logic signed [32:0]  z_q, z_d;
  logic [1:0]          quad_q, quad_d;
  logic signed [16:0]  s_q, s_d, c_q, c_d;
  logic signed [33:0]  rs_q, rs_d, rc_q, rc_d;
  logic signed [52:0]  acc_q, acc_d;
  logic signed [35:0]  ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic                ovalid_q, ovalid_d;
  s2tm_pkg::out_item_t out_q, out_d;

  logic [FW-1:0]       f_eff;
  logic [FW:0]         sr2;
  logic                sge;
  logic [FW-1:0]       srem_n;
  logic [31:0]         squo_n;
  logic [FW+1:0]       psum;
  logic [FW:0]         two_f;
  logic signed [33:0]  tx, ty, x_n, y_n;
  logic signed [32:0]  z_n, at;
  logic signed [16:0]  c0, s0;
  logic signed [33:0]  ma;
  logic signed [17:0]  mb;
  logic signed [51:0]  prod;
  logic signed [52:0]  accsum;
  logic signed [35:0]  offr;
  logic                last, emit;

  function automatic logic signed [16:0] clamp_q15(input logic signed [63:0] v);
    logic signed [16:0] res;
    if (v > 64'sd32768) begin
      res = s2tm_pkg::UNIT_Q15;
    end else if (v < -64'sd32768) begin
      res = s2tm_pkg::NEG_UNIT_Q15;
    end else begin
      res = 17'(v);
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] res;
    if (v > 37'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = 32'(v);
    end
    return res;
  endfunction

  assign pop_ready_o = (state_q == B_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  // Effective facet count.
  always_comb begin
    if (facets_i < 7'(s2tm_pkg::MIN_FACETS)) begin
      f_eff = FW'(s2tm_pkg::MIN_FACETS);
    end else if (facets_i > 7'(MAX_FACETS)) begin
      f_eff = FW'(MAX_FACETS);
    end else begin
      f_eff = FW'(facets_i);
    end
  end

  // Per-segment step of 2^32 / F, one quotient bit per cycle.
  assign sr2    = {srem_q, (cnt_q == 6'd0)};
  assign sge    = (sr2 >= {1'b0, f_q});
  assign srem_n = sge ? FW'(sr2 - {1'b0, f_q}) : FW'(sr2);
  assign squo_n = {squo_q[30:0], sge};

  // Phase accumulator: remainder kept in units of 1/(2F).
  assign two_f = {f_q, 1'b0};
  assign psum  = {1'b0, phr_q} + {1'b0, r0_q};

  // CORDIC rotation step.
  assign tx  = y_q >>> cnt_q[4:0];
  assign ty  = x_q >>> cnt_q[4:0];
  assign at  = $signed({3'b000, s2tm_pkg::atan_turns(cnt_q[4:0])});
  assign x_n = z_q[32] ? (x_q + tx) : (x_q - tx);
  assign y_n = z_q[32] ? (y_q - ty) : (y_q + ty);
  assign z_n = z_q[32] ? (z_q + at) : (z_q - at);
  assign c0  = clamp_q15(s2tm_pkg::rnd15(64'(x_n)));
  assign s0  = clamp_q15(s2tm_pkg::rnd15(64'(y_n)));

  // Shared multiplier: ring point products, then the rotated offsets.
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    begin ma = $signed({2'b00, r_q}); mb = 18'(s_q);            end
      3'd1:    begin ma = $signed({2'b00, r_q}); mb = 18'(c_q);            end
      3'd2:    begin ma = rs_q;                  mb = -18'(job_q.sz);      end
      3'd3:    begin ma = rc_q;                  mb = 18'(job_q.m02);      end
      3'd4:    begin ma = rs_q;                  mb = 18'(job_q.cz);       end
      3'd5:    begin ma = rc_q;                  mb = 18'(job_q.m12);      end
      default: begin ma = rc_q;                  mb = 18'(job_q.cy);       end
    endcase
  end
  assign prod   = 52'(ma) * 52'(mb);
  assign accsum = acc_q + 53'(prod);
  assign offr   = 36'(s2tm_pkg::rnd15(64'(accsum)));

  assign last = (k_q == f_q - 1'b1);
  assign emit = (state_q == B_EMIT) && (!ovalid_q || out_ready_i);

  // Facet sequencer.
  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    f_d      = f_q;
    k_d      = k_q;
    r_d      = r_q;
    base_d   = base_q;
    a_d      = a_q;
    cnt_d    = cnt_q;
    srem_d   = srem_q;
    squo_d   = squo_q;
    q0_d     = q0_q;
    r0_d     = r0_q;
    ph_d     = ph_q;
    phr_d    = phr_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    quad_d   = quad_q;
    s_d      = s_q;
    c_d      = c_q;
    rs_d     = rs_q;
    rc_d     = rc_q;
    acc_d    = acc_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    oz_d     = oz_q;
    ovalid_d = ovalid_q;
    out_d    = out_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          job_d  = pop_data_i;
          f_d    = f_eff;
          r_d    = (radius_i == '0) ? s2tm_pkg::DEFAULT_RADIUS : radius_i;
          if (pop_data_i.restart) begin
            base_d = '0;
            a_d    = '0;
          end else begin
            a_d = base_q;
          end
          srem_d  = '0;
          squo_d  = '0;
          cnt_d   = '0;
          state_d = B_SETUP;
        end
      end
      B_SETUP: begin
        srem_d = srem_n;
        squo_d = squo_n;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == 6'd32) begin
          q0_d    = squo_n;
          r0_d    = {srem_n, 1'b0};
          ph_d    = '0;
          phr_d   = {1'b0, f_q};
          k_d     = '0;
          x_d     = s2tm_pkg::CORDIC_START;
          y_d     = '0;
          z_d     = '0;
          quad_d  = '0;
          cnt_d   = '0;
          state_d = B_CORDIC;
        end
      end
      B_CORDIC: begin
        x_d   = x_n;
        y_d   = y_n;
        z_d   = z_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(s2tm_pkg::CORDIC_STEPS - 1)) begin
          case (quad_q)
            2'd0:    begin c_d = c0;  s_d = s0;  end
            2'd1:    begin c_d = -s0; s_d = c0;  end
            2'd2:    begin c_d = -c0; s_d = -s0; end
            default: begin c_d = s0;  s_d = -c0; end
          endcase
          cnt_d   = '0;
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        cnt_d = cnt_q + 1'b1;
        case (cnt_q[2:0])
          3'd0: begin
            rs_d = 34'(s2tm_pkg::rnd15(64'(prod)));
            // Advance the phase for the next facet.
            if (psum >= {1'b0, two_f}) begin
              phr_d = (FW + 1)'(psum - {1'b0, two_f});
              ph_d  = ph_q + q0_q + 32'd1;
            end else begin
              phr_d = (FW + 1)'(psum);
              ph_d  = ph_q + q0_q;
            end
          end
          3'd1:    rc_d  = 34'(s2tm_pkg::rnd15(64'(prod)));
          3'd2:    acc_d = 53'(prod);
          3'd3: begin
            ox_d  = offr;
            acc_d = '0;
          end
          3'd4:    acc_d = 53'(prod);
          3'd5: begin
            oy_d  = offr;
            acc_d = '0;
          end
          default: begin
            oz_d    = offr;
            state_d = B_EMIT;
          end
        endcase
      end
      B_EMIT: begin
        if (emit) begin
          ovalid_d         = 1'b1;
          out_d.near_x     = sat32(37'(job_q.begin_x) + 37'(ox_q));
          out_d.near_y     = sat32(37'(job_q.begin_y) + 37'(oy_q));
          out_d.near_z     = sat32(37'(job_q.begin_z) + 37'(oz_q));
          out_d.far_x      = sat32(37'(job_q.finish_x) + 37'(ox_q));
          out_d.far_y      = sat32(37'(job_q.finish_y) + 37'(oy_q));
          out_d.far_z      = sat32(37'(job_q.finish_z) + 37'(oz_q));
          out_d.quad_a     = a_q;
          out_d.quad_b     = a_q + IB'(1);
          out_d.quad_c     = last ? (base_d + IB'(1)) : (a_q + IB'(3));
          out_d.quad_d     = last ? base_d : (a_q + IB'(2));
          out_d.last_facet = last;
          a_d              = a_q + IB'(2);
          if (last) begin
            base_d  = a_q + IB'(2);
            state_d = B_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            x_d     = s2tm_pkg::CORDIC_START;
            y_d     = '0;
            z_d     = $signed({3'b000, ph_q[29:0]});
            quad_d  = ph_q[31:30];
            cnt_d   = '0;
            state_d = B_CORDIC;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
      base_q   <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      base_q   <= base_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    f_q    <= f_d;
    k_q    <= k_d;
    r_q    <= r_d;
    a_q    <= a_d;
    cnt_q  <= cnt_d;
    srem_q <= srem_d;
    squo_q <= squo_d;
    q0_q   <= q0_d;
    r0_q   <= r0_d;
    ph_q   <= ph_d;
    phr_q  <= phr_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
    s_q    <= s_d;
    c_q    <= c_d;
    rs_q   <= rs_d;
    rc_q   <= rc_d;
    acc_q  <= acc_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oz_q   <= oz_d;
    out_q  <= out_d;
  end

endmodule

// ----- rtl/segment_to_tube_mesh.sv -----
// Top level of the segment-to-tube block: configuration registers and the
// front part, queue and back part. Depends on s2tm_pkg, s2tm_front,
// s2tm_fifo and s2tm_back.
//
//   Port group   Direction  Handshake           Moves
//   in_*         input      valid / ready       one segment item (in_item_t)
//   out_*        output     valid / ready       one facet item (out_item_t)
//   APB          in / out   psel/penable/pready register writes and reads
//
// The back part runs a bit-serial setup division per segment, then per
// facet 24 CORDIC steps, 7 shared-multiplier steps and one output load.
// For a zero-length segment the front part skips its normalizer shifts,
// bit-serial square roots and dividers; it overlaps the back via the queue.
// Reset is asynchronous and active low; it clears control state, the vertex
// counter and the registers to their defaults. A stalled output holds the
// result while the next facet is already computed.
module segment_to_tube_mesh #(
  parameter int unsigned MAX_FACETS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  s2tm_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output s2tm_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [31:0]     radius_q, radius_d;
  logic [6:0]      facets_q, facets_d;
  logic            wr_en;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  s2tm_pkg::job_t  push_data, pop_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes.
  always_comb begin
    radius_d = radius_q;
    facets_d = facets_q;
    if (wr_en) begin
      case (paddr[2])
        s2tm_pkg::REG_TUBE_RADIUS: radius_d = pwdata;
        s2tm_pkg::REG_FACET_COUNT: facets_d = pwdata[6:0];
        default:                   radius_d = radius_q;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[2])
      s2tm_pkg::REG_TUBE_RADIUS: prdata = radius_q;
      s2tm_pkg::REG_FACET_COUNT: prdata = {25'b0, facets_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= s2tm_pkg::DEFAULT_RADIUS;
      facets_q <= s2tm_pkg::RESET_FACETS;
    end else begin
      radius_q <= radius_d;
      facets_q <= facets_d;
    end
  end

  s2tm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  s2tm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  s2tm_back #(
    .MAX_FACETS (MAX_FACETS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (radius_q),
    .facets_i    (facets_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
